[design/tmtf_pkg.sv]
// ----------------------------------------------------------------------------
// tmtf_pkg
// Shared widths and scaling constants for the trimmed-mean temperature filter.
// ----------------------------------------------------------------------------
package tmtf_pkg;

    localparam int RAW_W       = 16;
    localparam int FILT_W      = 11;
    localparam int CENTI_W     = 14;

    // 625/100 reduces to 25/4
    localparam int CENTI_MUL   = 25;
    localparam int CENTI_SHIFT = 2;

endpackage

[design/tmtf_in_if.sv]
// ----------------------------------------------------------------------------
// tmtf_in_if
// Valid/ready channel carrying one raw sensor reading per transfer.
// ----------------------------------------------------------------------------
interface tmtf_in_if
    import tmtf_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_reading;

    modport source (output valid, output raw_reading, input ready);
    modport sink   (input valid, input raw_reading, output ready);
endinterface

[design/tmtf_out_if.sv]
// ----------------------------------------------------------------------------
// tmtf_out_if
// Valid/ready channel carrying one filtered temperature result per transfer.
// ----------------------------------------------------------------------------
interface tmtf_out_if
    import tmtf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FILT_W-1:0]  filtered_raw;
    logic [CENTI_W-1:0] temperature_centi;

    modport source (output valid, output filtered_raw, output temperature_centi, input ready);
    modport sink   (input valid, input filtered_raw, input temperature_centi, output ready);
endinterface

[design/tmtf_cell.sv]
// ----------------------------------------------------------------------------
// tmtf_cell
// One cell of the window row. Holds max, min and sum of the samples from its
// position to the newest one, built from its neighbor's values plus the new
// sample on every shift.
// ----------------------------------------------------------------------------
module tmtf_cell #(
    parameter int SAMPLE_BITS = 11,
    parameter int SUM_W       = 14
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift_en,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] nb_max,
    input  logic [SAMPLE_BITS-1:0] nb_min,
    input  logic [SUM_W-1:0]       nb_sum,
    output logic [SAMPLE_BITS-1:0] agg_max,
    output logic [SAMPLE_BITS-1:0] agg_min,
    output logic [SUM_W-1:0]       agg_sum
);

    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;

    always_comb
    begin
        max_next = (sample > nb_max) ? sample : nb_max;
        min_next = (sample < nb_min) ? sample : nb_min;
        sum_next = nb_sum + SUM_W'(sample);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= '0;
            min_reg <= '0;
            sum_reg <= '0;
        end
        else if (shift_en)
        begin
            max_reg <= max_next;
            min_reg <= min_next;
            sum_reg <= sum_next;
        end
    end

    assign agg_max = max_reg;
    assign agg_min = min_reg;
    assign agg_sum = sum_reg;

endmodule

[design/tmtf_scale.sv]
// ----------------------------------------------------------------------------
// tmtf_scale
// Output register stage: drops one max and one min from the window sum,
// takes the mean and scales it to hundredths of a degree.
// ----------------------------------------------------------------------------
module tmtf_scale
    import tmtf_pkg::*;
#(
    parameter int WINDOW_LOG2 = 2,
    parameter int SAMPLE_BITS = 11
) (
    input  logic                   clk,
    input  logic                   load,
    input  logic [SAMPLE_BITS-1:0] win_max,
    input  logic [SAMPLE_BITS-1:0] win_min,
    input  logic [SAMPLE_BITS+WINDOW_LOG2:0] win_sum,
    output logic [FILT_W-1:0]      filtered_raw,
    output logic [CENTI_W-1:0]     temperature_centi
);

    localparam int SUM_W  = SAMPLE_BITS + WINDOW_LOG2 + 1;
    localparam int PROD_W = SAMPLE_BITS + 5;

    logic [SUM_W-1:0]           trimmed;
    logic [SAMPLE_BITS-1:0]     mean;
    logic [PROD_W-1:0]          prod;
    logic [PROD_W+CENTI_W-1:0]  prod_ext;
    logic [SAMPLE_BITS+FILT_W-1:0] mean_ext;
    logic [FILT_W-1:0]          filt_reg, filt_next;
    logic [CENTI_W-1:0]         centi_reg, centi_next;

    always_comb
    begin
        trimmed    = win_sum - SUM_W'(win_max) - SUM_W'(win_min);
        mean       = trimmed[WINDOW_LOG2+SAMPLE_BITS-1:WINDOW_LOG2];
        prod       = PROD_W'(mean) * PROD_W'(CENTI_MUL);
        prod_ext   = {{CENTI_W{1'b0}}, prod};
        mean_ext   = {{FILT_W{1'b0}}, mean};
        filt_next  = mean_ext[FILT_W-1:0];
        centi_next = prod_ext[CENTI_W+CENTI_SHIFT-1:CENTI_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            filt_reg  <= filt_next;
            centi_reg <= centi_next;
        end
    end

    assign filtered_raw      = filt_reg;
    assign temperature_centi = centi_reg;

endmodule

[design/trimmed_mean_temperature_filter.sv]
// ----------------------------------------------------------------------------
// trimmed_mean_temperature_filter
// Sliding-window trimmed mean of raw sensor readings, scaled to centidegrees.
// ----------------------------------------------------------------------------
// Takes one reading per cycle while the result sink is ready, masks it to
// SAMPLE_BITS and forms a window of 2^WINDOW_LOG2+2 samples with the previous
// ones (zero after reset). One max and one min are dropped, the rest averaged
// and scaled by 625/100. A row of cells keeps running max, min and sum for each
// window suffix; each reading is registered in the cell row, then in the
// tmtf_scale output register, and one result per cycle is sustained while the sink is ready.
module trimmed_mean_temperature_filter
    import tmtf_pkg::*;
#(
    parameter int WINDOW_LOG2 = 2,
    parameter int SAMPLE_BITS = 11
) (
    input  logic        clk,
    input  logic        rst_n,
    tmtf_in_if.sink     samples,
    tmtf_out_if.source  results
);

    localparam int SPAN  = (2 ** WINDOW_LOG2) + 2;
    localparam int SUM_W = SAMPLE_BITS + WINDOW_LOG2 + 1;

    logic                   accept;
    logic                   out_move;
    logic                   win_fire;
    logic                   win_valid_reg, win_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] sample;

    logic [SAMPLE_BITS-1:0] cell_max [SPAN];
    logic [SAMPLE_BITS-1:0] cell_min [SPAN];
    logic [SUM_W-1:0]       cell_sum [SPAN];

    assign sample        = samples.raw_reading[SAMPLE_BITS-1:0];
    assign out_move      = !out_valid_reg || results.ready;
    assign win_fire      = win_valid_reg && out_move;
    assign samples.ready = !win_valid_reg || out_move;
    assign accept        = samples.valid && samples.ready;

    // cell 0 holds the whole window, the last cell only the newest sample
    for (genvar k = 0; k < SPAN; k++)
    begin : g_cell
        if (k == SPAN - 1)
        begin : g_newest
            tmtf_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .SUM_W       (SUM_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (accept),
                .sample   (sample),
                .nb_max   ({SAMPLE_BITS{1'b0}}),
                .nb_min   ({SAMPLE_BITS{1'b1}}),
                .nb_sum   ({SUM_W{1'b0}}),
                .agg_max  (cell_max[k]),
                .agg_min  (cell_min[k]),
                .agg_sum  (cell_sum[k])
            );
        end
        else
        begin : g_inner
            tmtf_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .SUM_W       (SUM_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (accept),
                .sample   (sample),
                .nb_max   (cell_max[k+1]),
                .nb_min   (cell_min[k+1]),
                .nb_sum   (cell_sum[k+1]),
                .agg_max  (cell_max[k]),
                .agg_min  (cell_min[k]),
                .agg_sum  (cell_sum[k])
            );
        end
    end

    tmtf_scale #(
        .WINDOW_LOG2 (WINDOW_LOG2),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .clk               (clk),
        .load              (win_fire),
        .win_max           (cell_max[0]),
        .win_min           (cell_min[0]),
        .win_sum           (cell_sum[0]),
        .filtered_raw      (results.filtered_raw),
        .temperature_centi (results.temperature_centi)
    );

    always_comb
    begin
        win_valid_next = accept || (win_valid_reg && !out_move);
        out_valid_next = win_fire || (out_valid_reg && !results.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_valid_reg <= win_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign results.valid = out_valid_reg;

    a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
        win_fire |=> out_valid_reg)
        else $error("window result did not reach the output register");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (win_valid_reg && out_valid_reg && !results.ready) |-> !samples.ready)
        else $error("transfer taken while both stages are full and stalled");

    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        win_valid_reg |-> (cell_max[0] >= cell_min[0]))
        else $error("window max below window min");

endmodule
